>>> design/sfw_pkg.sv
// shared types and constants of the servo sync-write framer
// no dependencies; used by every module of the block
`default_nettype none

package sfw_pkg;

  localparam int MAX_ENTRIES = 83;
  localparam int COUNT_W     = 7;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 10;

  // register indexes of the configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INSTRUCTION   = 2'd2;

  localparam logic [COUNT_W-1:0] RST_SERVO_COUNT   = 7'd18;
  localparam logic [BYTE_W-1:0]  RST_START_ADDRESS = 8'd30;
  localparam logic [BYTE_W-1:0]  RST_INSTRUCTION   = 8'd131;

  localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'hff;
  localparam logic [BYTE_W-1:0] BCAST_ID      = 8'hfe;
  localparam logic [BYTE_W-1:0] DATA_LEN_BYTE = 8'd2;
  localparam logic [BYTE_W-1:0] LEN_OFFSET    = 8'd4;

  // entry queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // byte sequence of the back end
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_SYNC1 = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SYNC2 = 4'd1;
  localparam logic [STEP_W-1:0] STEP_BCAST = 4'd2;
  localparam logic [STEP_W-1:0] STEP_LEN   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_INSTR = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ADDR  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DLEN  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_ID    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_LO    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_HI    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_CSUM  = 4'd10;

  typedef struct packed {
    logic [BYTE_W-1:0] servo_id;
    logic [POS_W-1:0]  position;
    logic              first;
    logic              last;
    logic [BYTE_W-1:0] len_byte;
  } sfw_entry_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_address;
    logic [BYTE_W-1:0] instruction_code;
  } sfw_cfg_t;

endpackage

`default_nettype wire

>>> design/servo_sync_write_framer.sv
// Servo sync-write framer. An input word is one servo entry (servo_id, 10-bit
// position). The first entry of a packet is preceded by FF FF FE LEN INSTR ADDR 02,
// with LEN = 3*count+4; each entry gives ID, position low byte, position high byte;
// the entry that completes servo_count entries is followed by the checksum byte
// (inverted low byte of the sum from FE on) with out_packet_end high.
// Input side: push/full, a word is taken when in_push is high and in_full low.
// Output side: one byte per word; out_empty low means out_byte is valid, out_pop
// takes it. Configuration: cfg_valid/cfg_ready (always ready), cfg_index 0 is
// servo_count (0 acts as 1, above 83 saturates), 1 start_address, 2 instruction.
// Throughput: the output register moves one byte per cycle while out_pop keeps
// taking them; an entry is 3 bytes, 10 when it opens a packet and one more when it closes one.
// With the block idle, an accepted entry passes through the queue and then the
// output register before its first byte is on the outputs.
// A four-entry queue sits between the front end and the byte sequencer, so the
// input keeps accepting while the receiver stalls until that queue fills.
// Reset (rst_n low, synchronous) empties everything, restores servo_count 18,
// start_address 30, instruction 131, and starts a fresh packet.
// depends on sfw_pkg, sfw_front, sfw_queue, sfw_back
`default_nettype none

module servo_sync_write_framer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [sfw_pkg::BYTE_W-1:0]    in_servo_id,
  input  wire logic [sfw_pkg::POS_W-1:0]     in_position,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [sfw_pkg::BYTE_W-1:0]         out_byte,
  output logic                               out_packet_end,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sfw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sfw_pkg::BYTE_W-1:0]    cfg_data
);

  sfw_pkg::sfw_entry_t front_entry;
  sfw_pkg::sfw_entry_t head_entry;
  sfw_pkg::sfw_cfg_t   cfg;
  logic                accept;
  logic                q_full;
  logic                q_empty;
  logic                deq;
  logic                out_valid;
  logic                out_take;

  assign accept    = in_push && !q_full;
  assign in_full   = q_full;
  assign out_empty = !out_valid;
  assign out_take  = out_pop && out_valid;

  sfw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .servo_id  (in_servo_id),
    .position  (in_position),
    .entry     (front_entry),
    .cfg       (cfg)
  );

  sfw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_entry (front_entry),
    .rd_en    (deq),
    .rd_entry (head_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  sfw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (!q_empty),
    .head       (head_entry),
    .cfg        (cfg),
    .deq        (deq),
    .out_take   (out_take),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .out_last   (out_packet_end)
  );

  // the queue can never look full and empty at once
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("entry queue full and empty together");

  // an accepted word is in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !q_empty)
    else $error("accepted entry missing from queue");

  // the sequencer only retires an entry it is presenting
  a_deq_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    deq |-> !q_empty)
    else $error("dequeue from empty entry queue");

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result pending after reset");

endmodule

`default_nettype wire

>>> design/sfw_front.sv
// front end: configuration registers, entry counting and packet classification
// depends on sfw_pkg
`default_nettype none

module sfw_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sfw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sfw_pkg::BYTE_W-1:0]    cfg_data,
  input  wire logic                          accept,
  input  wire logic [sfw_pkg::BYTE_W-1:0]    servo_id,
  input  wire logic [sfw_pkg::POS_W-1:0]     position,
  output sfw_pkg::sfw_entry_t                entry,
  output sfw_pkg::sfw_cfg_t                  cfg
);

  logic [sfw_pkg::COUNT_W-1:0] servo_count_r;
  logic [sfw_pkg::BYTE_W-1:0]  start_address_r;
  logic [sfw_pkg::BYTE_W-1:0]  instruction_r;
  logic [sfw_pkg::COUNT_W-1:0] entry_index_r;
  logic [sfw_pkg::COUNT_W-1:0] entry_index_nxt;
  logic [sfw_pkg::COUNT_W-1:0] eff_count;
  logic [sfw_pkg::COUNT_W-1:0] index_inc;
  logic [sfw_pkg::COUNT_W+1:0] count_x3;
  logic                        last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_count_r   <= sfw_pkg::RST_SERVO_COUNT;
      start_address_r <= sfw_pkg::RST_START_ADDRESS;
      instruction_r   <= sfw_pkg::RST_INSTRUCTION;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sfw_pkg::CFG_SERVO_COUNT:   servo_count_r   <= cfg_data[sfw_pkg::COUNT_W-1:0];
        sfw_pkg::CFG_START_ADDRESS: start_address_r <= cfg_data;
        sfw_pkg::CFG_INSTRUCTION:   instruction_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    // zero counts as one, large counts saturate
    if (servo_count_r == '0) begin
      eff_count = sfw_pkg::COUNT_W'(1);
    end else if (servo_count_r > sfw_pkg::COUNT_W'(sfw_pkg::MAX_ENTRIES)) begin
      eff_count = sfw_pkg::COUNT_W'(sfw_pkg::MAX_ENTRIES);
    end else begin
      eff_count = servo_count_r;
    end
    count_x3  = {1'b0, eff_count, 1'b0} + {2'b00, eff_count};
    index_inc = entry_index_r + sfw_pkg::COUNT_W'(1);
    last      = index_inc >= eff_count;
    entry_index_nxt = last ? '0 : index_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_index_r <= '0;
    end else if (accept) begin
      entry_index_r <= entry_index_nxt;
    end
  end

  always_comb begin
    entry.servo_id = servo_id;
    entry.position = position;
    entry.first    = (entry_index_r == '0);
    entry.last     = last;
    entry.len_byte = count_x3[sfw_pkg::BYTE_W-1:0] + sfw_pkg::LEN_OFFSET;
    cfg.start_address    = start_address_r;
    cfg.instruction_code = instruction_r;
  end

endmodule

`default_nettype wire

>>> design/sfw_queue.sv
// short queue of classified entries between front and back end
// depends on sfw_pkg
`default_nettype none

module sfw_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire sfw_pkg::sfw_entry_t wr_entry,
  input  wire logic               rd_en,
  output sfw_pkg::sfw_entry_t     rd_entry,
  output logic                    full,
  output logic                    empty
);

  sfw_pkg::sfw_entry_t          slot_r [sfw_pkg::QUEUE_DEPTH];
  logic [sfw_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [sfw_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [sfw_pkg::QCNT_W-1:0]   count_r;
  logic [sfw_pkg::QCNT_W-1:0]   count_nxt;

  assign full     = (count_r == sfw_pkg::QCNT_W'(sfw_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign rd_entry = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + sfw_pkg::QCNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - sfw_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + sfw_pkg::QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + sfw_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/sfw_back.sv
// back end: walks the bytes of each entry, keeps the checksum, holds the output word
// depends on sfw_pkg
`default_nettype none

module sfw_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    head_valid,
  input  wire sfw_pkg::sfw_entry_t     head,
  input  wire sfw_pkg::sfw_cfg_t       cfg,
  output logic                         deq,
  input  wire logic                    out_take,
  output logic                         out_valid,
  output logic [sfw_pkg::BYTE_W-1:0]   out_byte,
  output logic                         out_last
);

  logic                         busy_r;
  logic [sfw_pkg::STEP_W-1:0]   step_r;
  logic [sfw_pkg::BYTE_W-1:0]   sum_r;
  logic [sfw_pkg::BYTE_W-1:0]   sum_nxt;
  logic                         out_valid_r;
  logic [sfw_pkg::BYTE_W-1:0]   out_byte_r;
  logic                         out_last_r;
  logic [sfw_pkg::STEP_W-1:0]   cur_step;
  logic [sfw_pkg::BYTE_W-1:0]   cur_byte;
  logic                         load;
  logic                         done;
  logic                         summed;

  always_comb begin
    cur_step = busy_r ? step_r : (head.first ? sfw_pkg::STEP_SYNC1 : sfw_pkg::STEP_ID);
    load     = head_valid && (!out_valid_r || out_take);
    unique case (cur_step)
      sfw_pkg::STEP_SYNC1: cur_byte = sfw_pkg::SYNC_BYTE;
      sfw_pkg::STEP_SYNC2: cur_byte = sfw_pkg::SYNC_BYTE;
      sfw_pkg::STEP_BCAST: cur_byte = sfw_pkg::BCAST_ID;
      sfw_pkg::STEP_LEN:   cur_byte = head.len_byte;
      sfw_pkg::STEP_INSTR: cur_byte = cfg.instruction_code;
      sfw_pkg::STEP_ADDR:  cur_byte = cfg.start_address;
      sfw_pkg::STEP_DLEN:  cur_byte = sfw_pkg::DATA_LEN_BYTE;
      sfw_pkg::STEP_ID:    cur_byte = head.servo_id;
      sfw_pkg::STEP_LO:    cur_byte = head.position[sfw_pkg::BYTE_W-1:0];
      sfw_pkg::STEP_HI:
        cur_byte = sfw_pkg::BYTE_W'(head.position[sfw_pkg::POS_W-1:sfw_pkg::BYTE_W]);
      sfw_pkg::STEP_CSUM:  cur_byte = ~sum_r;
      default:             cur_byte = '0;
    endcase
    // sync bytes and the checksum itself stay out of the sum
    summed = (cur_step != sfw_pkg::STEP_SYNC1) && (cur_step != sfw_pkg::STEP_SYNC2) &&
             (cur_step != sfw_pkg::STEP_CSUM);
    if (cur_step == sfw_pkg::STEP_SYNC1) begin
      sum_nxt = '0;
    end else if (summed) begin
      sum_nxt = sum_r + cur_byte;
    end else begin
      sum_nxt = sum_r;
    end
    done = ((cur_step == sfw_pkg::STEP_HI) && !head.last) ||
           (cur_step == sfw_pkg::STEP_CSUM);
    deq  = load && done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= sfw_pkg::STEP_SYNC1;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r      <= !done;
        step_r      <= cur_step + sfw_pkg::STEP_W'(1);
        sum_r       <= sum_nxt;
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cur_byte;
      out_last_r <= (cur_step == sfw_pkg::STEP_CSUM);
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire
